// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== hdl/phsac_pkg.sv =====
// ---------------------------------------------------------------------------
// phsac_pkg
// Shared types, constants and helpers of the pH sample average/classify unit.
// ---------------------------------------------------------------------------
package phsac_pkg;

    // averaging window (2..16)
    localparam int WINDOW   = 6;

    localparam int ADC_W    = 12;
    localparam int VOLT_W   = 18;
    localparam int SAMPLE_W = 16;
    localparam int PH_W     = 12;
    localparam int LIMIT_W  = 12;
    localparam int BAND_W   = 3;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W    = 18;

    localparam int CNT_W    = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

    // signed window sum
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

    // divide by WINDOW: floor reciprocal, one correction step
    localparam int RECIP_W  = SUM_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0]   WIN_CONST = SUM_W'(WINDOW);

    // volts = adc * round(3.3 * 2^16) >> 12
    localparam int VPROD_W  = ADC_W + VOLT_W;
    localparam logic [VPROD_W-1:0] VOLT_SCALE = VPROD_W'(216269);

    // Q8.8 slope times Q16 volts difference
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_W   = SAMPLE_W + VOLT_W + 1;
    localparam int CAL_W    = PROD_W - FRAC_SHIFT + 1;
    localparam logic signed [CAL_W-1:0] CAL_HI = CAL_W'(32767);
    localparam logic signed [CAL_W-1:0] CAL_LO = -CAL_W'(32768);

    localparam logic [PH_W-1:0] PH_MAX_Q8 = PH_W'(3584);
    localparam logic [PH_W-1:0] PH_BAD_Q8 = PH_W'(2534);

    // register reset values
    localparam logic [SAMPLE_W-1:0] SLOPE_RST       = 16'hFB00;
    localparam logic [VOLT_W-1:0]   VOLT_OFFSET_RST = VOLT_W'(131072);
    localparam logic [SAMPLE_W-1:0] PH_OFFSET_RST   = SAMPLE_W'(1792);
    localparam logic [LIMIT_W-1:0]  SACID_RST       = LIMIT_W'(768);
    localparam logic [LIMIT_W-1:0]  ACID_RST        = LIMIT_W'(1536);
    localparam logic [LIMIT_W-1:0]  BASE_RST        = LIMIT_W'(2048);
    localparam logic [LIMIT_W-1:0]  SBASE_RST       = LIMIT_W'(2816);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLOPE             = 3'd0,
        REG_VOLT_OFFSET       = 3'd1,
        REG_PH_OFFSET         = 3'd2,
        REG_STRONG_ACID_LIMIT = 3'd3,
        REG_ACID_LIMIT        = 3'd4,
        REG_BASE_LIMIT        = 3'd5,
        REG_STRONG_BASE_LIMIT = 3'd6
    } reg_index_t;

    localparam logic [BAND_W-1:0] BAND_STRONG_ACID = 3'd0;
    localparam logic [BAND_W-1:0] BAND_ACID        = 3'd1;
    localparam logic [BAND_W-1:0] BAND_NEUTRAL     = 3'd2;
    localparam logic [BAND_W-1:0] BAND_BASE        = 3'd3;
    localparam logic [BAND_W-1:0] BAND_STRONG_BASE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_CAL,
        ST_DIV,
        ST_FIX
    } state_t;

    // ring status handed from the cell row to the divider and value select
    typedef struct packed {
        logic signed [SUM_W-1:0]    sum;
        logic signed [SAMPLE_W-1:0] head;
        logic                       warm;
    } ring_status_t;

    // strong base wins, then base, acid, strong acid, else neutral
    function automatic logic [BAND_W-1:0] classify(
        input logic [PH_W-1:0]    p,
        input logic [LIMIT_W-1:0] sacid,
        input logic [LIMIT_W-1:0] acid,
        input logic [LIMIT_W-1:0] base,
        input logic [LIMIT_W-1:0] sbase
    );
        logic [BAND_W-1:0] b;
        if (p >= sbase)
            b = BAND_STRONG_BASE;
        else if (p > base)
            b = BAND_BASE;
        else if (p > sacid && p < acid)
            b = BAND_ACID;
        else if (p <= sacid)
            b = BAND_STRONG_ACID;
        else
            b = BAND_NEUTRAL;
        return b;
    endfunction

endpackage

// ===== hdl/phsac_cell.sv =====
// ---------------------------------------------------------------------------
// phsac_cell
// One window slot: holds a calibrated sample, takes its left neighbor's on shift.
// ---------------------------------------------------------------------------
module phsac_cell (
    input  logic                                   clk,
    input  logic                                   shift,
    input  logic signed [phsac_pkg::SAMPLE_W-1:0]  d,
    output logic signed [phsac_pkg::SAMPLE_W-1:0]  q
);

    logic signed [phsac_pkg::SAMPLE_W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
            val_reg <= d;
    end

    assign q = val_reg;

endmodule

// ===== hdl/phsac_ring.sv =====
// ---------------------------------------------------------------------------
// phsac_ring
// Row of window cells with running sum and warm-up tracking.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module phsac_ring (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   shift,
    input  logic signed [phsac_pkg::SAMPLE_W-1:0]  sample,
    output phsac_pkg::ring_status_t                status
);

    logic signed [phsac_pkg::SAMPLE_W-1:0] tap [phsac_pkg::WINDOW];

    logic signed [phsac_pkg::SUM_W-1:0] sum_reg;
    logic signed [phsac_pkg::SUM_W-1:0] sum_next;
    logic signed [phsac_pkg::SUM_W-1:0] add_term;
    logic signed [phsac_pkg::SUM_W-1:0] sub_term;
    logic [phsac_pkg::CNT_W-1:0]        cnt_reg;
    logic                               warm_reg;

    // cell 0 takes the new sample, the last cell holds the oldest one
    for (genvar i = 0; i < phsac_pkg::WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            phsac_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (sample),
                .q     (tap[i])
            );
        end
        else
        begin : g_body
            phsac_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (tap[i-1]),
                .q     (tap[i])
            );
        end
    end

    always_comb
    begin
        add_term = {{(phsac_pkg::SUM_W - phsac_pkg::SAMPLE_W){sample[phsac_pkg::SAMPLE_W-1]}},
                    sample};
        // oldest sample only leaves once the window is full
        if (warm_reg)
            sub_term = {{(phsac_pkg::SUM_W - phsac_pkg::SAMPLE_W)
                        {tap[phsac_pkg::WINDOW-1][phsac_pkg::SAMPLE_W-1]}},
                        tap[phsac_pkg::WINDOW-1]};
        else
            sub_term = '0;
        sum_next = sum_reg + add_term - sub_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            warm_reg <= 1'b0;
        end
        else if (shift)
        begin
            sum_reg <= sum_next;
            if (!warm_reg)
            begin
                if (cnt_reg == phsac_pkg::CNT_LAST)
                begin
                    cnt_reg  <= '0;
                    warm_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign status.sum  = sum_reg;
    assign status.head = tap[0];
    assign status.warm = warm_reg;

    `ASSERT_CLK(a_warm_sticky, clk, rst_n, warm_reg |=> warm_reg, "warm flag dropped")
    `ASSERT_CLK(a_warm_on_fill, clk, rst_n, (shift && !warm_reg && cnt_reg == phsac_pkg::CNT_LAST) |=> warm_reg, "window full but warm not set")
    `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_reg > phsac_pkg::CNT_LAST, "fill count past window")

endmodule

// ===== hdl/ph_sample_average_classify_unit.sv =====
// ---------------------------------------------------------------------------
// ph_sample_average_classify_unit
// ADC sample to calibrated Q8 pH, moving average over the window (the fresh
// sample until it is full), range check and five-band classification.
// ---------------------------------------------------------------------------
// Steps of a word, in order: volts on accept, calibrate multiply, cell shift,
//   divide multiply, correction/classify into the output register; the last
//   step waits while the output register holds a stalled result.
// The single sequencer runs one word at a time and takes the next one while
//   the last result waits downstream.
// Reset: async active low; config registers go to their defaults, the sum,
//   fill count and warm flag clear. Cell contents are not reset.
`include "assert_macros.svh"

module ph_sample_average_classify_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // input word
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [phsac_pkg::ADC_W-1:0]            adc_sample,

    // result word
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [phsac_pkg::PH_W-1:0]             ph_value,
    output logic [phsac_pkg::BAND_W-1:0]           band,
    output logic                                   out_of_range,
    output logic                                   averaged,

    // config write port
    input  logic                                   cfg_we,
    input  logic [phsac_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [phsac_pkg::CFG_W-1:0]            cfg_data
);

    // -----------------------------------------------------------------------
    // Config registers
    // -----------------------------------------------------------------------
    logic signed [phsac_pkg::SAMPLE_W-1:0] slope_reg;
    logic [phsac_pkg::VOLT_W-1:0]          voff_reg;
    logic signed [phsac_pkg::SAMPLE_W-1:0] phoff_reg;
    logic [phsac_pkg::LIMIT_W-1:0]         sacid_reg;
    logic [phsac_pkg::LIMIT_W-1:0]         acid_reg;
    logic [phsac_pkg::LIMIT_W-1:0]         base_reg;
    logic [phsac_pkg::LIMIT_W-1:0]         sbase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg <= phsac_pkg::SLOPE_RST;
            voff_reg  <= phsac_pkg::VOLT_OFFSET_RST;
            phoff_reg <= phsac_pkg::PH_OFFSET_RST;
            sacid_reg <= phsac_pkg::SACID_RST;
            acid_reg  <= phsac_pkg::ACID_RST;
            base_reg  <= phsac_pkg::BASE_RST;
            sbase_reg <= phsac_pkg::SBASE_RST;
        end
        else if (cfg_we)
        begin
            // indexes past the list are dropped
            unique case (cfg_index)
                phsac_pkg::REG_SLOPE:
                    slope_reg <= cfg_data[phsac_pkg::SAMPLE_W-1:0];
                phsac_pkg::REG_VOLT_OFFSET:
                    voff_reg <= cfg_data[phsac_pkg::VOLT_W-1:0];
                phsac_pkg::REG_PH_OFFSET:
                    phoff_reg <= cfg_data[phsac_pkg::SAMPLE_W-1:0];
                phsac_pkg::REG_STRONG_ACID_LIMIT:
                    sacid_reg <= cfg_data[phsac_pkg::LIMIT_W-1:0];
                phsac_pkg::REG_ACID_LIMIT:
                    acid_reg <= cfg_data[phsac_pkg::LIMIT_W-1:0];
                phsac_pkg::REG_BASE_LIMIT:
                    base_reg <= cfg_data[phsac_pkg::LIMIT_W-1:0];
                phsac_pkg::REG_STRONG_BASE_LIMIT:
                    sbase_reg <= cfg_data[phsac_pkg::LIMIT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    phsac_pkg::state_t state_reg;
    phsac_pkg::state_t state_next;

    logic in_take;
    logic out_load;
    logic shift_en;
    logic out_valid_reg;

    assign in_take = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            phsac_pkg::ST_IDLE:
                if (in_valid)
                    state_next = phsac_pkg::ST_PROD;
            phsac_pkg::ST_PROD:
                state_next = phsac_pkg::ST_CAL;
            phsac_pkg::ST_CAL:
                state_next = phsac_pkg::ST_DIV;
            phsac_pkg::ST_DIV:
                state_next = phsac_pkg::ST_FIX;
            phsac_pkg::ST_FIX:
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                    state_next = phsac_pkg::ST_IDLE;
            default:
                state_next = phsac_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != phsac_pkg::ST_IDLE);
        shift_en = (state_reg == phsac_pkg::ST_CAL);
        out_load = (state_reg == phsac_pkg::ST_FIX) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= phsac_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // -----------------------------------------------------------------------
    // Volts: registered straight from the accepted word
    // -----------------------------------------------------------------------
    logic [phsac_pkg::VPROD_W-1:0] vprod;
    logic [phsac_pkg::VOLT_W-1:0]  volts_reg;

    assign vprod = phsac_pkg::VPROD_W'(adc_sample) * phsac_pkg::VOLT_SCALE;

    always_ff @(posedge clk)
    begin
        if (in_take)
            volts_reg <= vprod[phsac_pkg::VPROD_W-1:phsac_pkg::ADC_W];
    end

    // -----------------------------------------------------------------------
    // Calibration product: slope * (v - volt_offset)
    // -----------------------------------------------------------------------
    logic signed [phsac_pkg::VOLT_W:0]   vdiff;
    logic signed [phsac_pkg::PROD_W-1:0] slope_ext;
    logic signed [phsac_pkg::PROD_W-1:0] vdiff_ext;
    logic signed [phsac_pkg::PROD_W-1:0] prod_next;
    logic signed [phsac_pkg::PROD_W-1:0] prod_reg;

    always_comb
    begin
        vdiff     = $signed({1'b0, volts_reg}) - $signed({1'b0, voff_reg});
        slope_ext = {{(phsac_pkg::PROD_W - phsac_pkg::SAMPLE_W){slope_reg[phsac_pkg::SAMPLE_W-1]}},
                     slope_reg};
        vdiff_ext = {{(phsac_pkg::PROD_W - phsac_pkg::VOLT_W - 1){vdiff[phsac_pkg::VOLT_W]}},
                     vdiff};
        prod_next = slope_ext * vdiff_ext;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == phsac_pkg::ST_PROD)
            prod_reg <= prod_next;
    end

    // -----------------------------------------------------------------------
    // Q24 -> Q8 floor shift, add pH offset, clamp to 16 bits signed
    // -----------------------------------------------------------------------
    logic signed [phsac_pkg::CAL_W-1:0]    cal_wide;
    logic signed [phsac_pkg::SAMPLE_W-1:0] cal_sample;

    always_comb
    begin
        cal_wide = {prod_reg[phsac_pkg::PROD_W-1], prod_reg[phsac_pkg::PROD_W-1:phsac_pkg::FRAC_SHIFT]}
                 + {{(phsac_pkg::CAL_W - phsac_pkg::SAMPLE_W){phoff_reg[phsac_pkg::SAMPLE_W-1]}},
                    phoff_reg};
        if (cal_wide > phsac_pkg::CAL_HI)
            cal_sample = phsac_pkg::CAL_HI[phsac_pkg::SAMPLE_W-1:0];
        else if (cal_wide < phsac_pkg::CAL_LO)
            cal_sample = phsac_pkg::CAL_LO[phsac_pkg::SAMPLE_W-1:0];
        else
            cal_sample = cal_wide[phsac_pkg::SAMPLE_W-1:0];
    end

    // -----------------------------------------------------------------------
    // Window cells
    // -----------------------------------------------------------------------
    phsac_pkg::ring_status_t ring_st;

    phsac_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (shift_en),
        .sample (cal_sample),
        .status (ring_st)
    );

    // -----------------------------------------------------------------------
    // Sum / WINDOW toward zero: magnitude times floor reciprocal, then one
    // correction step (estimate is low by at most one)
    // -----------------------------------------------------------------------
    logic                                           neg_next;
    logic [phsac_pkg::SUM_W-1:0]                    mag_next;
    logic [phsac_pkg::SUM_W+phsac_pkg::RECIP_W-1:0] qprod;
    logic                                           neg_reg;
    logic [phsac_pkg::SUM_W-1:0]                    mag_reg;
    logic [phsac_pkg::SUM_W-1:0]                    q0_reg;

    always_comb
    begin
        neg_next = ring_st.sum[phsac_pkg::SUM_W-1];
        mag_next = neg_next ? phsac_pkg::SUM_W'(-ring_st.sum) : phsac_pkg::SUM_W'(ring_st.sum);
        qprod    = (phsac_pkg::SUM_W + phsac_pkg::RECIP_W)'(mag_next)
                 * (phsac_pkg::SUM_W + phsac_pkg::RECIP_W)'(phsac_pkg::DIV_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == phsac_pkg::ST_DIV)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
            q0_reg  <= qprod[phsac_pkg::SUM_W+phsac_pkg::RECIP_W-1:phsac_pkg::RECIP_W];
        end
    end

    // -----------------------------------------------------------------------
    // Correction, value select, range check, band
    // -----------------------------------------------------------------------
    logic [phsac_pkg::SUM_W-1:0]     rem;
    logic [phsac_pkg::SUM_W-1:0]     quot;
    logic signed [phsac_pkg::SUM_W:0] value;
    logic                             bad;
    logic [phsac_pkg::PH_W-1:0]       reported;
    logic [phsac_pkg::BAND_W-1:0]     band_next;

    always_comb
    begin
        rem  = mag_reg - q0_reg * phsac_pkg::WIN_CONST;
        quot = (rem >= phsac_pkg::WIN_CONST) ? q0_reg + 1'b1 : q0_reg;

        // average once the window is full, else the fresh sample
        if (ring_st.warm)
            value = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        else
            value = {{(phsac_pkg::SUM_W + 1 - phsac_pkg::SAMPLE_W){ring_st.head[phsac_pkg::SAMPLE_W-1]}},
                     ring_st.head};

        bad = value[phsac_pkg::SUM_W]
           || (value[phsac_pkg::SUM_W-1:0] > phsac_pkg::SUM_W'(phsac_pkg::PH_MAX_Q8));
        reported  = bad ? phsac_pkg::PH_BAD_Q8 : value[phsac_pkg::PH_W-1:0];
        band_next = phsac_pkg::classify(reported, sacid_reg, acid_reg, base_reg, sbase_reg);
    end

    // -----------------------------------------------------------------------
    // Output register
    // -----------------------------------------------------------------------
    logic [phsac_pkg::PH_W-1:0]   ph_value_reg;
    logic [phsac_pkg::BAND_W-1:0] band_reg;
    logic                         oor_reg;
    logic                         avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ph_value_reg <= reported;
            band_reg     <= band_next;
            oor_reg      <= bad;
            avg_reg      <= ring_st.warm;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ph_value     = ph_value_reg;
    assign band         = band_reg;
    assign out_of_range = oor_reg;
    assign averaged     = avg_reg;

    // -----------------------------------------------------------------------
    // Checks
    // -----------------------------------------------------------------------
    `ASSERT_CLK(a_accept_starts, clk, rst_n, in_take |=> (state_reg == phsac_pkg::ST_PROD), "accepted word did not start the sequence")
    `ASSERT_CLK(a_fix_holds, clk, rst_n, (state_reg == phsac_pkg::ST_FIX && out_valid_reg && out_stall) |=> (state_reg == phsac_pkg::ST_FIX), "result left while output was full")
    `ASSERT_NEVER(a_bad_value, clk, rst_n, out_valid && out_of_range && (ph_value != phsac_pkg::PH_BAD_Q8), "out of range word without substitute value")

endmodule
